// ----- sv/fpdf_pkg.sv -----
// Shared types, constants and helper functions for the fixed-point decimal formatter.
`default_nettype none

package fpdf_pkg;

   localparam int unsigned DATA_W           = 64;
   localparam int unsigned BCD_DIGITS       = 20;
   localparam int unsigned BCD_W            = 4 * BCD_DIGITS;
   localparam int unsigned DIGIT_IDX_W      = 5;
   localparam int unsigned STEP_W           = 6;
   localparam int unsigned COUNT_W          = 4;
   localparam int unsigned MAX_FRAC_DIGITS  = 10;
   localparam int unsigned REQ_DATA_W       = 136;
   localparam int unsigned RSP_DATA_W       = 8;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   // divider control
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // 10^k for k = 0..9
   function automatic logic [63:0] pow10(input logic [3:0] k);
      logic [63:0] p;
      case (k)
         4'd0:    p = 64'd1;
         4'd1:    p = 64'd10;
         4'd2:    p = 64'd100;
         4'd3:    p = 64'd1000;
         4'd4:    p = 64'd10000;
         4'd5:    p = 64'd100000;
         4'd6:    p = 64'd1000000;
         4'd7:    p = 64'd10000000;
         4'd8:    p = 64'd100000000;
         4'd9:    p = 64'd1000000000;
         default: p = 64'd1;
      endcase
      return p;
   endfunction

   // add-3 correction on every BCD digit ahead of a left shift
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
      logic [BCD_W-1:0] r;
      logic [3:0]       d;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = v[4*i +: 4];
         r[4*i +: 4] = (d >= 4'd5) ? 4'(d + 4'd3) : d;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/fixed_point_decimal_formatter_top.sv -----
// Top level of the fixed-point decimal formatter: sequencer, BCD converter, output register.
`default_nettype none
// Usage:
//   req_* takes one number per item: whole part, scaled fraction and a fraction
//   digit count (counts above MAX_FRACTION_DIGITS saturate). rsp_* returns the
//   ASCII characters of the number, most significant first, one per item, with
//   rsp_tlast on the final character.
//   Sequence per number: 64 steps of shift-and-add-3 on the whole part, run
//   alongside a bit-serial divide of the fraction by 10^(count-1); a step to
//   find the leading digit; the whole digits; '.' and the leading fraction
//   character; then, if fraction digits remain, a second pass of the same BCD
//   unit over the DIV_W-bit remainder (30 bits at the default limit) and the
//   remaining fraction digits.
//   req_tready is high only while the sequencer is idle; one number at a time.
//   A character sits in the output register until taken; while rsp_tready is
//   low the sequencer waits, so nothing is lost. The next number may be taken
//   while the last character still waits.
//   Reset (synchronous, active high) returns to idle and drops rsp_tvalid.

module fixed_point_decimal_formatter_top #(
   parameter int unsigned MAX_FRACTION_DIGITS = fpdf_pkg::MAX_FRAC_DIGITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: whole_part[63:0], fraction_part[127:64], fraction_digits[131:128], zero pad
   input  wire logic [fpdf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: character[7:0]
   output logic      [fpdf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready
);
   import fpdf_pkg::*;

   // divisor width: enough for 10^(MAX_FRACTION_DIGITS-1)
   localparam int unsigned DIV_W =
      $clog2(pow10(4'(MAX_FRACTION_DIGITS - 1)) + 64'd1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_LEAD  = 3'd2;
   localparam logic [2:0] ST_WHOLE = 3'd3;
   localparam logic [2:0] ST_DOT   = 3'd4;
   localparam logic [2:0] ST_QCHAR = 3'd5;
   localparam logic [2:0] ST_FCONV = 3'd6;
   localparam logic [2:0] ST_FRAC  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [DATA_W-1:0]      src_ff, src_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0]     ndig_ff, ndig_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]             rsp_tdata_ff, rsp_tdata_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;

   logic [DATA_W-1:0]      req_whole;
   logic [DATA_W-1:0]      req_frac;
   logic [COUNT_W-1:0]     req_ndig;
   logic [COUNT_W-1:0]     ndig_sat;
   logic                   accept;
   logic                   out_free;
   logic                   out_load;
   logic [7:0]             out_char;
   logic                   out_last;
   logic [3:0]             digit;
   logic [DIGIT_IDX_W-1:0] top_idx;
   logic [BCD_W-1:0]       bcd_adj;
   logic [BCD_W-1:0]       bcd_step;

   div_ctrl_type           div_ctrl;
   logic [DIV_W-1:0]       div_divisor;
   logic [7:0]             div_quo;
   logic [DIV_W-1:0]       div_rem;

   assign req_whole = req_tdata[63:0];
   assign req_frac  = req_tdata[127:64];
   assign req_ndig  = req_tdata[131:128];
   assign ndig_sat  = (32'(req_ndig) > MAX_FRACTION_DIGITS) ?
                      COUNT_W'(MAX_FRACTION_DIGITS) : req_ndig;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // 10^(count-1); unused when count is zero
   assign div_divisor = (ndig_sat == '0) ? DIV_W'(1) : DIV_W'(pow10(4'(ndig_sat - 4'd1)));

   fpdf_divider #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock        (clock),
      .ctrl         (div_ctrl),
      .dividend     (req_frac),
      .divisor      (div_divisor),
      .quotient_low (div_quo),
      .remainder    (div_rem)
   );

   // one double-dabble step: adjust, then shift the next source bit in
   assign bcd_adj  = bcd_adjust(bcd_ff);
   assign bcd_step = {bcd_adj[BCD_W-2:0], src_ff[DATA_W-1]};

   // current BCD digit for emission
   assign digit = bcd_ff[4*idx_ff +: 4];

   // highest nonzero BCD digit (zero if all digits are zero)
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) top_idx = DIGIT_IDX_W'(i);
      end
   end

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      bcd_in        = bcd_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      ndig_in       = ndig_ff;
      div_ctrl.load = 1'b0;
      div_ctrl.step = 1'b0;
      out_load      = 1'b0;
      out_char      = CHAR_ZERO;
      out_last      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               src_in        = req_whole;
               bcd_in        = '0;
               step_in       = STEP_W'(DATA_W - 1);
               ndig_in       = ndig_sat;
               div_ctrl.load = 1'b1;
               state_in      = ST_CONV;
            end
         end
         ST_CONV: begin
            // whole part to BCD and fraction divide share the 64 steps
            src_in        = {src_ff[DATA_W-2:0], 1'b0};
            bcd_in        = bcd_step;
            div_ctrl.step = 1'b1;
            step_in       = step_ff - 1'b1;
            if (step_ff == '0) state_in = ST_LEAD;
         end
         ST_LEAD: begin
            idx_in   = top_idx;
            state_in = ST_WHOLE;
         end
         ST_WHOLE: begin
            out_char = CHAR_ZERO + {4'd0, digit};
            out_last = (idx_ff == '0) && (ndig_ff == '0);
            if (out_free) begin
               out_load = 1'b1;
               idx_in   = idx_ff - 1'b1;
               if (idx_ff == '0) state_in = (ndig_ff == '0) ? ST_IDLE : ST_DOT;
            end
         end
         ST_DOT: begin
            out_char = CHAR_DOT;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_QCHAR;
            end
         end
         ST_QCHAR: begin
            // wraps mod 256 when the fraction is out of range
            out_char = CHAR_ZERO + div_quo;
            out_last = (ndig_ff == 4'd1);
            if (out_free) begin
               out_load = 1'b1;
               if (ndig_ff == 4'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  src_in   = DATA_W'(div_rem) << (DATA_W - DIV_W);
                  bcd_in   = '0;
                  step_in  = STEP_W'(DIV_W - 1);
                  state_in = ST_FCONV;
               end
            end
         end
         ST_FCONV: begin
            src_in  = {src_ff[DATA_W-2:0], 1'b0};
            bcd_in  = bcd_step;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               idx_in   = DIGIT_IDX_W'(ndig_ff - 4'd2);
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            out_char = CHAR_ZERO + {4'd0, digit};
            out_last = (idx_ff == '0);
            if (out_free) begin
               out_load = 1'b1;
               idx_in   = idx_ff - 1'b1;
               if (idx_ff == '0) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid_in = out_load || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tdata_in  = out_load ? out_char : rsp_tdata_ff;
   assign rsp_tlast_in  = out_load ? out_last : rsp_tlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      bcd_ff       <= bcd_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      ndig_ff      <= ndig_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // one number at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item taken while a conversion was starting");

   // converted digits are proper BCD
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WHOLE || state_ff == ST_FRAC) |-> (digit <= 4'd9))
      else $error("BCD digit out of range");

   // the flagged character closes the sequence
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer still busy after last character");

   // remainder pass only when digits remain after the leading fraction character
   a_fconv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FCONV) |-> (ndig_ff >= 4'd2))
      else $error("remainder pass with too few fraction digits");

endmodule

`default_nettype wire

// ----- sv/fpdf_divider.sv -----
// Bit-serial restoring divider: one quotient bit per step.
`default_nettype none

module fpdf_divider #(
   parameter int unsigned DIV_W = 30
) (
   input  wire logic                        clock,
   input  wire fpdf_pkg::div_ctrl_type      ctrl,
   input  wire logic [63:0]                 dividend,
   input  wire logic [DIV_W-1:0]            divisor,
   output logic      [7:0]                  quotient_low,
   output logic      [DIV_W-1:0]            remainder
);
   import fpdf_pkg::*;

   logic [DATA_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [7:0]        quo_ff, quo_in;
   logic [DIV_W:0]    rem_sh;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DATA_W-1]};
      ge     = (rem_sh >= {1'b0, dsr_ff});
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctrl.load) begin
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (ctrl.step) begin
         dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
         rem_in = ge ? DIV_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DIV_W-1:0];
         quo_in = {quo_ff[6:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient_low = quo_ff;
   assign remainder    = rem_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the fixed-point decimal formatter: random bursts, stalls and a text predictor.
module testbench;

   import fpdf_pkg::*;

   localparam int unsigned FRAC_LIMIT  = MAX_FRAC_DIGITS;
   localparam int unsigned WHOLE_DIGS  = 20;
   localparam int          RANDOM_NUMS = 130;
   localparam int          DRAIN_WAIT  = 200;   // cycles of extra wait after everything owed is back

   // one number to format, as it goes onto req_tdata
   typedef struct {
      logic [63:0] whole;
      logic [63:0] frac;
      logic [3:0]  digits;
      logic        drain_first;   // hold off until every owed character is back
   } number_type;

   // one expected output character
   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_type;

   // receiver behavior, switched at random
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_STALLS
   } ready_mode_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;

   number_type     pending_numbers[$];    // filled up front, drained by the driver
   char_type       expected_chars[$];     // predicted text, oldest first
   number_type     held_number;           // number currently offered on req_*
   int             chars_predicted = 0;   // NBA-updated by the driver only
   int             chars_seen      = 0;   // NBA-updated by the monitor only
   int             fail_count      = 0;
   int             burst_left      = 0;
   int             gap_left        = 0;
   ready_mode_type ready_mode      = READY_ALWAYS;
   int             mode_left       = 0;
   int             stall_left      = 0;

   fixed_point_decimal_formatter_top #(
      .MAX_FRACTION_DIGITS(FRAC_LIMIT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin : clock_gen
      forever #10 clock = ~clock;
   end

   // Hard stop.
   initial begin : watchdog
      #8000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] ten_to(input int unsigned n);
      logic [63:0] p;
      p = 64'd1;
      for (int unsigned k = 0; k < n; k++) p = p * 64'd10;
      return p;
   endfunction

   // Expected text of one number: whole digits, then, for a nonzero count, '.' and the fraction digits.
   // Returns the character count and appends the run to expected_chars.
   function automatic int format_decimal(input number_type num);
      logic [3:0]  whole_digs[WHOLE_DIGS];
      logic [7:0]  text[$];
      logic [63:0] w;
      logic [63:0] f;
      logic [63:0] scale;
      logic [63:0] q;
      int unsigned cnt;
      int          n;
      char_type    c;

      w   = num.whole;
      f   = num.frac;
      cnt = num.digits;
      n   = 0;
      if (cnt > FRAC_LIMIT) cnt = FRAC_LIMIT;   // saturate the digit count

      // whole part, least significant digit first; zero still yields one digit
      whole_digs[0] = 4'd0;
      while (n == 0 || (w != 64'd0 && n < WHOLE_DIGS)) begin
         whole_digs[n] = 4'(w % 64'd10);
         w = w / 64'd10;
         n++;
      end
      for (int i = n - 1; i >= 0; i--) text.push_back(CHAR_ZERO + 8'(whole_digs[i]));

      if (cnt > 0) begin
         text.push_back(CHAR_DOT);
         scale = ten_to(cnt - 1);
         for (int unsigned k = 0; k < cnt; k++) begin
            // an oversized fraction leaves a wide quotient; only its low byte shows
            q = f / scale;
            text.push_back(8'(CHAR_ZERO + q[7:0]));
            f = f % scale;
            if (scale > 64'd1) scale = scale / 64'd10;
         end
      end

      foreach (text[i]) begin
         c.code = text[i];
         c.last = (i == text.size() - 1);
         expected_chars.push_back(c);
      end
      return text.size();
   endfunction

   task automatic add_number(input logic [63:0] whole, input logic [63:0] frac,
                             input logic [3:0] digits, input logic drain_first);
      number_type num;
      num.whole       = whole;
      num.frac        = frac;
      num.digits      = digits;
      num.drain_first = drain_first;
      pending_numbers.push_back(num);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: bursts of numbers separated by random gaps. One NBA to req_tvalid
   // per edge; the next number is loaded only after the held one is taken.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic next_valid;
      logic taken;

      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         next_valid = req_tvalid;
         taken      = req_tvalid && req_tready;
         if (taken) begin
            chars_predicted <= chars_predicted + format_decimal(held_number);
            next_valid = 1'b0;
         end
         if (!next_valid && pending_numbers.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_numbers[0].drain_first &&
                         (taken || chars_seen != chars_predicted)) begin
               // wait for the block to hand back everything owed so far
            end else begin
               held_number = pending_numbers.pop_front();
               req_tdata  <= {4'b0, held_number.digits, held_number.frac, held_number.whole};
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver backpressure: always ready, coin flip, or random stall runs.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      logic rdy;

      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rdy = 1'b1;
            READY_COIN:   rdy = 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rdy = 1'b0;
               end else begin
                  rdy = 1'b1;
                  if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
               end
            end
         endcase
         rsp_tready <= rdy;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: every accepted character against the oldest expectation.
   // The counters are NBA-updated, so the "anything owed?" test is race-free.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      char_type want;

      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chars_seen == chars_predicted) begin
            $error("unexpected character: code=%0h last=%0b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.code) begin
               $error("character: expected %0h, got %0h", want.code, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_tlast);
               fail_count++;
            end
            chars_seen <= chars_seen + 1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [63:0]  whole;
      logic [63:0]  frac;
      logic [3:0]   digits;
      int unsigned  eff;

      // directed: whole-part extremes, integer only
      add_number(64'd0, 64'd0, 4'd0, 1'b0);
      add_number(64'd1, 64'd0, 4'd0, 1'b0);
      add_number(64'd9, 64'd0, 4'd0, 1'b0);
      add_number(64'd10, 64'd0, 4'd0, 1'b0);
      add_number('1, '1, 4'd0, 1'b0);                          // 20 digits, fraction ignored
      add_number(64'd10000000000000000000, 64'd0, 4'd0, 1'b0);
      // ordinary fractions, one and full width
      add_number(64'd12345, 64'd5, 4'd1, 1'b0);
      add_number(64'd0, 64'd0, 4'd10, 1'b0);
      add_number(64'd0, 64'd1, 4'd10, 1'b0);
      add_number('1, 64'd9999999999, 4'd10, 1'b0);             // longest run, 31 characters
      add_number(64'd42, 64'd123, 4'd3, 1'b1);                 // after a full drain
      // counts past the limit saturate
      add_number(64'd7, 64'd9999999999, 4'd15, 1'b0);
      add_number(64'd0, 64'd0, 4'd15, 1'b0);
      add_number(64'd5, 64'd5, 4'd12, 1'b0);
      add_number(64'd100, 64'd12345678901, 4'd11, 1'b0);
      // oversized fractions: leading character wraps past '9'
      add_number(64'd3, '1, 4'd1, 1'b0);
      add_number(64'd3, 64'd10, 4'd1, 1'b0);
      add_number(64'd0, 64'd200, 4'd2, 1'b0);
      add_number(64'd99999, 64'd1000, 4'd3, 1'b0);
      add_number('1, '1, 4'd10, 1'b0);
      add_number(64'd1, 64'h8000_0000_0000_0000, 4'd9, 1'b1);

      // random: mixed magnitudes, mostly in-range fractions
      for (int n = 0; n < RANDOM_NUMS; n++) begin
         whole  = ($urandom_range(0, 4) == 0) ? rand64() : rand64() >> $urandom_range(0, 63);
         digits = 4'($urandom_range(0, 15));
         eff    = (digits > FRAC_LIMIT) ? FRAC_LIMIT : digits;
         if (eff != 0 && $urandom_range(0, 4) != 0)
            frac = rand64() % ten_to(eff);
         else if ($urandom_range(0, 1) == 0)
            frac = rand64();
         else
            frac = rand64() >> $urandom_range(0, 63);
         add_number(whole, frac, digits, 1'($urandom_range(0, 19) == 0));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_numbers.size() != 0 || req_tvalid || chars_seen != chars_predicted)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (fail_count == 0 && chars_seen == chars_predicted)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
